// File: src/esbhm_pkg.sv
// Shared types and constants for the engine speed band hour meter.
package esbhm_pkg;

    typedef enum logic [2:0] {
        BAND_OFF       = 3'd0,
        BAND_IDLE      = 3'd1,
        BAND_CLIMB     = 3'd2,
        BAND_CRUISE    = 3'd3,
        BAND_CAUTION   = 3'd4,
        BAND_REDLINE   = 3'd5,
        BAND_OVERLIMIT = 3'd6
    } t_band;

    typedef enum logic [1:0] {
        HEALTH_OK      = 2'd0,
        HEALTH_SERVICE = 2'd1,
        HEALTH_FAIL    = 2'd2
    } t_health;

    typedef enum logic [2:0] {
        CFG_IDLE_FLOOR      = 3'd0,
        CFG_IDLE_CEILING    = 3'd1,
        CFG_CLIMB_CEILING   = 3'd2,
        CFG_CRUISE_CEILING  = 3'd3,
        CFG_CAUTION_CEILING = 3'd4,
        CFG_REDLINE_CEILING = 3'd5,
        CFG_FAIL_LIMIT      = 3'd6,
        CFG_SERVICE_LIMIT   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [14:0] idle_floor;
        logic [14:0] idle_ceiling;
        logic [14:0] climb_ceiling;
        logic [14:0] cruise_ceiling;
        logic [14:0] caution_ceiling;
        logic [14:0] redline_ceiling;
    } t_band_cfg;

    typedef struct packed {
        logic s2_load;
        logic s3_load;
        logic s4_load;
        logic s5_load;
    } t_pipe_ctrl;

    localparam logic [14:0] IDLE_FLOOR_RST      = 15'd1000;
    localparam logic [14:0] IDLE_CEILING_RST    = 15'd3500;
    localparam logic [14:0] CLIMB_CEILING_RST   = 15'd6000;
    localparam logic [14:0] CRUISE_CEILING_RST  = 15'd9000;
    localparam logic [14:0] CAUTION_CEILING_RST = 15'd9799;
    localparam logic [14:0] REDLINE_CEILING_RST = 15'd10200;
    localparam logic [31:0] FAIL_LIMIT_RST      = 32'd14400;
    localparam logic [31:0] SERVICE_LIMIT_RST   = 32'd3600;

    localparam logic [31:0] CAUTION_SERVICE_SEC = 32'd10800;

    // round(30/pi * 2^24)
    localparam logic [27:0] RPM_K    = 28'd160210611;
    localparam logic [47:0] RPM_HALF = 48'h0000_8000_0000;
    localparam logic [14:0] RPM_MAX  = 15'd32767;

    // ceil(2^36 / 225), exact for 28-bit dividends after the shift by 4.
    localparam logic [28:0] HOUR_RECIP = 29'd305419897;
    // ceil(2^14 / 15), exact for 10-bit dividends after the shift by 2.
    localparam logic [10:0] MIN_RECIP  = 11'd1093;

endpackage

// File: src/engine_speed_band_hour_meter.sv
// Top level of the engine speed band hour meter. Each tick transfer carries a
// shaft speed and elapsed seconds and yields exactly one result transfer. The
// block takes one tick in every cycle unless a stalled output has filled all stages: the
// five-stage pipeline (input register, rpm multiply, band and accumulator
// update, health and hours reciprocal multiply, minutes and seconds split into
// the output register) moves all stages independently, so a stalled output
// only holds back the items behind it while empty stages keep filling.
// Configuration registers must be written while no tick is in flight.
module engine_speed_band_hour_meter
    import esbhm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [18:0] i_shaft_speed_q8,
    input  logic [15:0] i_elapsed_sec,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_engine_rpm,
    output logic [2:0]  o_band_code,
    output logic [31:0] o_run_total_sec,
    output logic [20:0] o_run_hours,
    output logic [5:0]  o_run_minutes,
    output logic [5:0]  o_run_seconds,
    output logic [31:0] o_caution_total_sec,
    output logic [31:0] o_redline_total_sec,
    output logic [1:0]  o_health_code
);

    t_band_cfg   r_band_cfg;
    logic [31:0] r_fail_limit;
    logic [31:0] r_service_limit;

    logic [4:0]  r_valid;
    logic [4:0]  n_valid;
    logic [4:0]  free;
    logic [4:0]  load;
    t_pipe_ctrl  ctrl;

    logic [18:0] r_s1_speed;
    logic [15:0] r_s1_dt;
    logic [14:0] s2_rpm;
    logic [15:0] s2_dt;
    logic [14:0] s3_rpm;
    t_band       s3_band;
    logic [31:0] s3_run;
    logic [31:0] s3_caution;
    logic [31:0] s3_redline;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_cfg.idle_floor      <= IDLE_FLOOR_RST;
            r_band_cfg.idle_ceiling    <= IDLE_CEILING_RST;
            r_band_cfg.climb_ceiling   <= CLIMB_CEILING_RST;
            r_band_cfg.cruise_ceiling  <= CRUISE_CEILING_RST;
            r_band_cfg.caution_ceiling <= CAUTION_CEILING_RST;
            r_band_cfg.redline_ceiling <= REDLINE_CEILING_RST;
            r_fail_limit               <= FAIL_LIMIT_RST;
            r_service_limit            <= SERVICE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_IDLE_FLOOR:      r_band_cfg.idle_floor      <= i_cfg_data[14:0];
                CFG_IDLE_CEILING:    r_band_cfg.idle_ceiling    <= i_cfg_data[14:0];
                CFG_CLIMB_CEILING:   r_band_cfg.climb_ceiling   <= i_cfg_data[14:0];
                CFG_CRUISE_CEILING:  r_band_cfg.cruise_ceiling  <= i_cfg_data[14:0];
                CFG_CAUTION_CEILING: r_band_cfg.caution_ceiling <= i_cfg_data[14:0];
                CFG_REDLINE_CEILING: r_band_cfg.redline_ceiling <= i_cfg_data[14:0];
                CFG_FAIL_LIMIT:      r_fail_limit               <= i_cfg_data;
                CFG_SERVICE_LIMIT:   r_service_limit            <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage is free when it is empty or its item moves on in this cycle.
    always_comb begin
        free[4] = !r_valid[4] || i_out_ready;
        load[4] = r_valid[3] && free[4];
        free[3] = !r_valid[3] || load[4];
        load[3] = r_valid[2] && free[3];
        free[2] = !r_valid[2] || load[3];
        load[2] = r_valid[1] && free[2];
        free[1] = !r_valid[1] || load[2];
        load[1] = r_valid[0] && free[1];
        free[0] = !r_valid[0] || load[1];
        load[0] = i_in_valid && free[0];
        n_valid = load | (r_valid & ~free);
        ctrl.s2_load = load[1];
        ctrl.s3_load = load[2];
        ctrl.s4_load = load[3];
        ctrl.s5_load = load[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_s1_speed <= i_shaft_speed_q8;
            r_s1_dt    <= i_elapsed_sec;
        end
    end

    esbhm_rpm u_rpm (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .i_speed_q8 (r_s1_speed),
        .i_dt       (r_s1_dt),
        .o_rpm      (s2_rpm),
        .o_dt       (s2_dt)
    );

    esbhm_band_acc u_band_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_cfg     (r_band_cfg),
        .i_rpm     (s2_rpm),
        .i_dt      (s2_dt),
        .o_rpm     (s3_rpm),
        .o_band    (s3_band),
        .o_run     (s3_run),
        .o_caution (s3_caution),
        .o_redline (s3_redline)
    );

    esbhm_report u_report (
        .i_clk               (i_clk),
        .i_ctrl              (ctrl),
        .i_fail_limit        (r_fail_limit),
        .i_service_limit     (r_service_limit),
        .i_rpm               (s3_rpm),
        .i_band              (s3_band),
        .i_run               (s3_run),
        .i_caution           (s3_caution),
        .i_redline           (s3_redline),
        .o_engine_rpm        (o_engine_rpm),
        .o_band_code         (o_band_code),
        .o_run_total_sec     (o_run_total_sec),
        .o_run_hours         (o_run_hours),
        .o_run_minutes       (o_run_minutes),
        .o_run_seconds       (o_run_seconds),
        .o_caution_total_sec (o_caution_total_sec),
        .o_redline_total_sec (o_redline_total_sec),
        .o_health_code       (o_health_code)
    );

    assign o_in_ready  = free[0];
    assign o_out_valid = r_valid[4];

    a_full_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("Input stalled while the pipeline could advance.");

    a_time_split_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_minutes < 6'd60 && o_run_seconds < 6'd60))
        else $error("Minutes or seconds of running time out of range.");

    a_run_covers_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_run_total_sec >= o_caution_total_sec &&
                         o_run_total_sec >= o_redline_total_sec))
        else $error("Running time is below a band total.");

endmodule

// File: src/esbhm_rpm.sv
// Speed to rpm conversion stage with its result register.
module esbhm_rpm
    import esbhm_pkg::*;
(
    input  logic        i_clk,
    input  t_pipe_ctrl  i_ctrl,
    input  logic [18:0] i_speed_q8,
    input  logic [15:0] i_dt,
    output logic [14:0] o_rpm,
    output logic [15:0] o_dt
);

    logic [46:0] prod;
    logic [47:0] rnd;
    logic [15:0] rpm_full;
    logic [14:0] n_rpm;
    logic [14:0] r_rpm;
    logic [15:0] r_dt;

    always_comb begin
        prod     = 47'(i_speed_q8) * 47'(RPM_K);
        rnd      = {1'b0, prod} + RPM_HALF;
        rpm_full = rnd[47:32];
        n_rpm    = (rpm_full > {1'b0, RPM_MAX}) ? RPM_MAX : rpm_full[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s2_load) begin
            r_rpm <= n_rpm;
            r_dt  <= i_dt;
        end
    end

    assign o_rpm = r_rpm;
    assign o_dt  = r_dt;

endmodule

// File: src/esbhm_band_acc.sv
// Band classification and the saturating time accumulators.
module esbhm_band_acc
    import esbhm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pipe_ctrl  i_ctrl,
    input  t_band_cfg   i_cfg,
    input  logic [14:0] i_rpm,
    input  logic [15:0] i_dt,
    output logic [14:0] o_rpm,
    output t_band       o_band,
    output logic [31:0] o_run,
    output logic [31:0] o_caution,
    output logic [31:0] o_redline
);

    t_band       band;
    logic [32:0] run_sum;
    logic [32:0] caution_sum;
    logic [32:0] redline_sum;
    logic [31:0] n_run;
    logic [31:0] n_caution;
    logic [31:0] n_redline;
    logic [14:0] r_rpm;
    t_band       r_band;
    logic [31:0] r_run;
    logic [31:0] r_caution;
    logic [31:0] r_redline;

    always_comb begin
        priority if (i_rpm == 15'd0 || i_rpm < i_cfg.idle_floor) begin
            band = BAND_OFF;
        end else if (i_rpm <= i_cfg.idle_ceiling) begin
            band = BAND_IDLE;
        end else if (i_rpm <= i_cfg.climb_ceiling) begin
            band = BAND_CLIMB;
        end else if (i_rpm <= i_cfg.cruise_ceiling) begin
            band = BAND_CRUISE;
        end else if (i_rpm <= i_cfg.caution_ceiling) begin
            band = BAND_CAUTION;
        end else if (i_rpm <= i_cfg.redline_ceiling) begin
            band = BAND_REDLINE;
        end else begin
            band = BAND_OVERLIMIT;
        end
    end

    always_comb begin
        run_sum     = {1'b0, r_run} + {17'd0, i_dt};
        caution_sum = {1'b0, r_caution} + {17'd0, i_dt};
        redline_sum = {1'b0, r_redline} + {17'd0, i_dt};
        n_run       = r_run;
        n_caution   = r_caution;
        n_redline   = r_redline;
        if (band != BAND_OFF) begin
            n_run = run_sum[32] ? 32'hFFFF_FFFF : run_sum[31:0];
        end
        if (band == BAND_CAUTION) begin
            n_caution = caution_sum[32] ? 32'hFFFF_FFFF : caution_sum[31:0];
        end
        if (band == BAND_REDLINE || band == BAND_OVERLIMIT) begin
            n_redline = redline_sum[32] ? 32'hFFFF_FFFF : redline_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= '0;
            r_caution <= '0;
            r_redline <= '0;
        end else if (i_ctrl.s3_load) begin
            r_run     <= n_run;
            r_caution <= n_caution;
            r_redline <= n_redline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s3_load) begin
            r_rpm  <= i_rpm;
            r_band <= band;
        end
    end

    assign o_rpm     = r_rpm;
    assign o_band    = r_band;
    assign o_run     = r_run;
    assign o_caution = r_caution;
    assign o_redline = r_redline;

endmodule

// File: src/esbhm_report.sv
// Health verdict and the hours, minutes and seconds split of running time.
module esbhm_report
    import esbhm_pkg::*;
(
    input  logic        i_clk,
    input  t_pipe_ctrl  i_ctrl,
    input  logic [31:0] i_fail_limit,
    input  logic [31:0] i_service_limit,
    input  logic [14:0] i_rpm,
    input  t_band       i_band,
    input  logic [31:0] i_run,
    input  logic [31:0] i_caution,
    input  logic [31:0] i_redline,
    output logic [14:0] o_engine_rpm,
    output logic [2:0]  o_band_code,
    output logic [31:0] o_run_total_sec,
    output logic [20:0] o_run_hours,
    output logic [5:0]  o_run_minutes,
    output logic [5:0]  o_run_seconds,
    output logic [31:0] o_caution_total_sec,
    output logic [31:0] o_redline_total_sec,
    output logic [1:0]  o_health_code
);

    t_health     health;
    logic [56:0] hour_prod;
    logic [14:0] r4_rpm;
    t_band       r4_band;
    logic [31:0] r4_run;
    logic [31:0] r4_caution;
    logic [31:0] r4_redline;
    t_health     r4_health;
    logic [20:0] r4_hours;

    logic [31:0] hours_ext;
    logic [31:0] hour_secs;
    logic [31:0] diff;
    logic [11:0] rem;
    logic [20:0] min_prod;
    logic [5:0]  minutes;
    logic [11:0] min_secs;
    logic [11:0] sec_diff;

    logic [14:0] r5_rpm;
    t_band       r5_band;
    logic [31:0] r5_run;
    logic [20:0] r5_hours;
    logic [5:0]  r5_minutes;
    logic [5:0]  r5_seconds;
    logic [31:0] r5_caution;
    logic [31:0] r5_redline;
    t_health     r5_health;

    always_comb begin
        priority if (i_redline > i_fail_limit) begin
            health = HEALTH_FAIL;
        end else if (i_redline > i_service_limit || i_caution > CAUTION_SERVICE_SEC) begin
            health = HEALTH_SERVICE;
        end else begin
            health = HEALTH_OK;
        end
        hour_prod = 57'(i_run[31:4]) * 57'(HOUR_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s4_load) begin
            r4_rpm     <= i_rpm;
            r4_band    <= i_band;
            r4_run     <= i_run;
            r4_caution <= i_caution;
            r4_redline <= i_redline;
            r4_health  <= health;
            r4_hours   <= hour_prod[56:36];
        end
    end

    // 3600 = 4096 - 512 + 16 and 60 = 64 - 4.
    always_comb begin
        hours_ext = {11'd0, r4_hours};
        hour_secs = (hours_ext << 12) - (hours_ext << 9) + (hours_ext << 4);
        diff      = r4_run - hour_secs;
        rem       = diff[11:0];
        min_prod  = 21'(rem[11:2]) * 21'(MIN_RECIP);
        minutes   = min_prod[19:14];
        min_secs  = ({6'd0, minutes} << 6) - ({6'd0, minutes} << 2);
        sec_diff  = rem - min_secs;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.s5_load) begin
            r5_rpm     <= r4_rpm;
            r5_band    <= r4_band;
            r5_run     <= r4_run;
            r5_hours   <= r4_hours;
            r5_minutes <= minutes;
            r5_seconds <= sec_diff[5:0];
            r5_caution <= r4_caution;
            r5_redline <= r4_redline;
            r5_health  <= r4_health;
        end
    end

    assign o_engine_rpm        = r5_rpm;
    assign o_band_code         = r5_band;
    assign o_run_total_sec     = r5_run;
    assign o_run_hours         = r5_hours;
    assign o_run_minutes       = r5_minutes;
    assign o_run_seconds       = r5_seconds;
    assign o_caution_total_sec = r5_caution;
    assign o_redline_total_sec = r5_redline;
    assign o_health_code       = r5_health;

endmodule
